FILE: hdl/usb_control_endpoint_handler_top_assert.svh
// Assertion macros shared by the control endpoint checker.
`ifndef USB_CONTROL_ENDPOINT_HANDLER_TOP_ASSERT_SVH
`define USB_CONTROL_ENDPOINT_HANDLER_TOP_ASSERT_SVH

// Checked at every rising edge outside of reset.
`define UCEP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define UCEP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/ucep_pkg.sv
// Types, codes and descriptor constants of the control endpoint handler.
`timescale 1ns / 1ps
package ucep_pkg;

  // Endpoint event codes.
  typedef enum logic [2:0] {
    FUNC_SETUP     = 3'd0,
    FUNC_IN_DONE   = 3'd1,
    FUNC_OUT_DONE  = 3'd2,
    FUNC_BUS_RESET = 3'd3,
    FUNC_ENUM_DONE = 3'd4
  } func_e;

  // Result action codes.
  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_STALL     = 3'd1,
    ACT_ACK       = 3'd2,
    ACT_IN_FIRST  = 3'd3,
    ACT_IN_NEXT   = 3'd4,
    ACT_OUT_ARM   = 3'd5,
    ACT_SPEED_ERR = 3'd6
  } action_e;

  // Data sources of IN chunks.
  localparam logic [2:0] SRC_STATUS  = 3'd0;
  localparam logic [2:0] SRC_DEVICE  = 3'd1;
  localparam logic [2:0] SRC_CONFIG  = 3'd2;
  localparam logic [2:0] SRC_STRING0 = 3'd3;
  localparam logic [2:0] SRC_CFG_VAL = 3'd7;

  // Request words: bRequest in the high byte, bmRequestType in the low byte.
  localparam logic [15:0] REQ_GET_STATUS     = 16'h0080;
  localparam logic [15:0] REQ_SET_ADDRESS    = 16'h0500;
  localparam logic [15:0] REQ_GET_DESCRIPTOR = 16'h0680;
  localparam logic [15:0] REQ_GET_CONFIG     = 16'h0880;
  localparam logic [15:0] REQ_SET_CONFIG     = 16'h0900;

  // Descriptor types in the high byte of wValue.
  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;

  // Reply lengths in bytes.
  localparam logic [4:0] LEN_STATUS  = 5'd2;
  localparam logic [4:0] LEN_DEVICE  = 5'd18;
  localparam logic [4:0] LEN_CONFIG  = 5'd9;
  localparam logic [4:0] LEN_CFG_VAL = 5'd1;

  // Link speed codes and packet sizes.
  localparam logic [1:0] SPEED_LOW  = 2'd2;
  localparam logic [1:0] SPEED_FULL = 2'd3;
  localparam logic [6:0] PKT_LOW    = 7'd8;
  localparam logic [6:0] PKT_FULL   = 7'd64;

  localparam logic [7:0] CFG_RESET = 8'd1;

  // One endpoint event.
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] setup_value;
    logic [15:0] setup_index;
    logic [15:0] setup_length;
    logic [6:0]  out_received;
    logic [1:0]  link_speed;
  } item_t;

  // One result.
  typedef struct packed {
    action_e    action;
    logic [2:0] data_source;
    logic [5:0] chunk_offset;
    logic [6:0] chunk_length;
    logic       address_valid;
    logic [6:0] new_address;
  } result_t;

  // String descriptor lengths.
  function automatic logic [4:0] string_len(input logic [1:0] idx);
    logic [4:0] len;
    unique case (idx)
      2'd0: len = 5'd4;
      2'd1: len = 5'd16;
      2'd2: len = 5'd22;
      default: len = 5'd26;
    endcase
    return len;
  endfunction

endpackage

FILE: hdl/usb_control_endpoint_handler_top.sv
// Top level of the USB endpoint-zero control handler.
// The event is held in the input register, decoded, and then held in the result register.
// Throughput: one event per cycle while the result register is not stalled.
// A stalled result register holds the input register, which then stalls the sender.
// Reset clears both valid flags and the endpoint state; the packet size resets to 64
// and the configuration value to 1.
`timescale 1ns / 1ps
module usb_control_endpoint_handler_top #(
  parameter int MAX_OUT_DATA = 64,
  parameter int NUM_STRINGS  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  configuration_value_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] setup_value_i,
  input  logic [15:0] setup_index_i,
  input  logic [15:0] setup_length_i,
  input  logic [6:0]  out_received_i,
  input  logic [1:0]  link_speed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [2:0]  data_source_o,
  output logic [5:0]  chunk_offset_o,
  output logic [6:0]  chunk_length_o,
  output logic        address_valid_o,
  output logic [6:0]  new_address_o
);
  import ucep_pkg::*;

  item_t   item_in;
  item_t   item_held;
  logic    held_valid;
  logic    advance;
  result_t result_d;
  result_t result_q;

  assign item_in = '{
    func:         func_i,
    request_type: request_type_i,
    request_code: request_code_i,
    setup_value:  setup_value_i,
    setup_index:  setup_index_i,
    setup_length: setup_length_i,
    out_received: out_received_i,
    link_speed:   link_speed_i
  };

  // The configuration register takes every write.
  assign cfg_ready_o = 1'b1;

  ucep_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .item_o     (item_held)
  );

  ucep_core #(
    .MAX_OUT_DATA (MAX_OUT_DATA),
    .NUM_STRINGS  (NUM_STRINGS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (configuration_value_i),
    .step_i     (advance),
    .item_i     (item_held),
    .result_o   (result_d)
  );

  ucep_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (held_valid),
    .result_i    (result_d),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_q)
  );

  // Result fields.
  assign action_o        = result_q.action;
  assign data_source_o   = result_q.data_source;
  assign chunk_offset_o  = result_q.chunk_offset;
  assign chunk_length_o  = result_q.chunk_length;
  assign address_valid_o = result_q.address_valid;
  assign new_address_o   = result_q.new_address;

endmodule

FILE: hdl/ucep_in_stage.sv
// Input register of the control endpoint handler.
`timescale 1ns / 1ps
module ucep_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ucep_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output ucep_pkg::item_t item_o
);
  import ucep_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  load;

  // Hold off the sender only while a held event cannot move on.
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // Event payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hdl/ucep_core.sv
// Request decode and endpoint state of the control endpoint handler.
`timescale 1ns / 1ps
module ucep_core #(
  parameter int MAX_OUT_DATA = 64,
  parameter int NUM_STRINGS  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              step_i,
  input  ucep_pkg::item_t   item_i,
  output ucep_pkg::result_t result_o
);
  import ucep_pkg::*;

  logic [7:0] cfg_q;
  logic [6:0] remain_q, remain_d;
  logic [6:0] pkt_q, pkt_d;
  logic [5:0] pos_q, pos_d;
  logic [2:0] src_q, src_d;

  logic [15:0] req;
  logic [7:0]  dtype;
  logic [7:0]  didx;
  logic        found;
  logic [4:0]  len;
  logic [2:0]  src;
  logic [6:0]  len_cap;
  logic [6:0] remain_sub;
  result_t     res;

  assign req        = {item_i.request_code, item_i.request_type};
  assign dtype      = item_i.setup_value[15:8];
  assign didx       = item_i.setup_value[7:0];
  assign remain_sub = remain_q - pkt_q;

  // Descriptor lookup for device-to-host requests.
  always_comb begin
    found = 1'b0;
    len   = '0;
    src   = SRC_STATUS;
    if (req == REQ_GET_STATUS) begin
      found = 1'b1;
      len   = LEN_STATUS;
      src   = SRC_STATUS;
    end else if (req == REQ_GET_DESCRIPTOR) begin
      if (dtype == DESC_DEVICE && didx == 8'd0) begin
        found = 1'b1;
        len   = LEN_DEVICE;
        src   = SRC_DEVICE;
      end else if (dtype == DESC_CONFIG && didx == 8'd0) begin
        found = 1'b1;
        len   = LEN_CONFIG;
        src   = SRC_CONFIG;
      end else if (dtype == DESC_STRING && didx < 8'(NUM_STRINGS) && didx < 8'd4) begin
        found = 1'b1;
        len   = string_len(didx[1:0]);
        src   = SRC_STRING0 + {1'b0, didx[1:0]};
      end
    end else if (req == REQ_GET_CONFIG) begin
      found = 1'b1;
      len   = LEN_CFG_VAL;
      src   = SRC_CFG_VAL;
    end
    // The reply never runs past wLength.
    len_cap = (item_i.setup_length < {11'd0, len}) ? item_i.setup_length[6:0]
                                                  : {2'd0, len};
  end

  // Event handling and next state.
  always_comb begin
    remain_d = remain_q;
    pkt_d    = pkt_q;
    pos_d    = pos_q;
    src_d    = src_q;
    res      = '0;
    res.action = ACT_NONE;
    unique case (item_i.func)
      FUNC_SETUP: begin
        remain_d = '0;
        pos_d    = '0;
        if (item_i.request_type[7]) begin
          if (found) begin
            remain_d         = len_cap;
            src_d            = src;
            res.action       = ACT_IN_FIRST;
            res.data_source  = src;
            res.chunk_length = (len_cap < pkt_q) ? len_cap : pkt_q;
          end else begin
            res.action = ACT_STALL;
          end
        end else if (item_i.setup_length == 16'd0) begin
          if (req == REQ_SET_ADDRESS) begin
            res.action        = ACT_ACK;
            res.address_valid = 1'b1;
            res.new_address   = item_i.setup_value[6:0];
          end else if (req == REQ_SET_CONFIG && item_i.setup_index == 16'd0 &&
                       item_i.setup_value == {8'd0, cfg_q}) begin
            res.action = ACT_ACK;
          end else begin
            res.action = ACT_STALL;
          end
        end else if (item_i.setup_length <= 16'(MAX_OUT_DATA)) begin
          remain_d         = item_i.setup_length[6:0];
          res.action       = ACT_OUT_ARM;
          res.chunk_length = pkt_q;
        end else begin
          res.action = ACT_STALL;
        end
      end
      FUNC_IN_DONE: begin
        if (remain_q != '0) begin
          if (remain_q > pkt_q) begin
            remain_d         = remain_sub;
            pos_d            = pos_q + pkt_q[5:0];
            res.action       = ACT_IN_NEXT;
            res.data_source  = src_q;
            res.chunk_offset = pos_q + pkt_q[5:0];
            res.chunk_length = (remain_sub < pkt_q) ? remain_sub : pkt_q;
          end else begin
            remain_d = '0;
          end
        end
      end
      FUNC_OUT_DONE: begin
        if (remain_q != '0) begin
          if (item_i.out_received >= remain_q) begin
            remain_d   = '0;
            res.action = ACT_STALL;
          end else begin
            remain_d         = remain_q - item_i.out_received;
            res.action       = ACT_OUT_ARM;
            res.chunk_length = pkt_q;
          end
        end
      end
      FUNC_BUS_RESET: begin
        remain_d = '0;
      end
      FUNC_ENUM_DONE: begin
        if (item_i.link_speed == SPEED_LOW) begin
          pkt_d = PKT_LOW;
        end else if (item_i.link_speed == SPEED_FULL) begin
          pkt_d = PKT_FULL;
        end else begin
          res.action = ACT_SPEED_ERR;
        end
      end
      default: begin
        res.action = ACT_NONE;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Endpoint state, updated as each event moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
      pkt_q    <= PKT_FULL;
      pos_q    <= '0;
      src_q    <= SRC_STATUS;
    end else if (step_i) begin
      remain_q <= remain_d;
      pkt_q    <= pkt_d;
      pos_q    <= pos_d;
      src_q    <= src_d;
    end
  end

  assign result_o = res;

endmodule

FILE: hdl/ucep_out_stage.sv
// Result register of the control endpoint handler.
`timescale 1ns / 1ps
module ucep_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ucep_pkg::result_t result_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ucep_pkg::result_t result_o
);
  import ucep_pkg::*;

  logic    valid_q;
  result_t result_q;
  logic    ready;

  // The register takes a new result when empty or when its transfer completes.
  assign ready     = !valid_q || !out_stall_i;
  assign advance_o = valid_i && ready;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= valid_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

FILE: hdl/ucep_checker.sv
// Port-level checker for the control endpoint handler and its bind.
`timescale 1ns / 1ps
`include "usb_control_endpoint_handler_top_assert.svh"
module ucep_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] action_o,
  input logic [2:0] data_source_o,
  input logic [5:0] chunk_offset_o,
  input logic [6:0] chunk_length_o,
  input logic       address_valid_o
);
  import ucep_pkg::*;

  // No result is offered while reset is applied.
  `UCEP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

  // A stalled result transfer keeps its action.
  `UCEP_ASSERT_RST(a_stall_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o), "stalled result changed")

  // Source and offset are only set on IN chunks.
  `UCEP_ASSERT_RST(a_src_zero, out_valid_o && action_o != ACT_IN_FIRST && action_o != ACT_IN_NEXT |-> data_source_o == 3'd0 && chunk_offset_o == 6'd0, "source or offset set outside IN chunk")

  // Length is only set on IN chunks and OUT arming.
  `UCEP_ASSERT_RST(a_len_zero, out_valid_o && action_o != ACT_IN_FIRST && action_o != ACT_IN_NEXT && action_o != ACT_OUT_ARM |-> chunk_length_o == 7'd0, "length set outside data action")

  // A new address only comes with an acknowledge.
  `UCEP_ASSERT_RST(a_addr_ack, out_valid_o && address_valid_o |-> action_o == ACT_ACK, "address without acknowledge")

endmodule

bind usb_control_endpoint_handler_top ucep_checker u_checker (.*);

FILE: bench/usb_control_endpoint_handler_top_tb.sv
// Self-checking testbench of the USB endpoint-zero control handler.
`timescale 1ns / 1ps
module usb_control_endpoint_handler_top_tb;
  import ucep_pkg::*;

  localparam int MAX_OUT = 64;
  localparam int STRINGS = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  configuration_value_i = 8'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func_i = 3'd0;
  logic [7:0]  request_type_i = 8'd0;
  logic [7:0]  request_code_i = 8'd0;
  logic [15:0] setup_value_i = 16'd0;
  logic [15:0] setup_index_i = 16'd0;
  logic [15:0] setup_length_i = 16'd0;
  logic [6:0]  out_received_i = 7'd0;
  logic [1:0]  link_speed_i = 2'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  action_o;
  logic [2:0]  data_source_o;
  logic [5:0]  chunk_offset_o;
  logic [6:0]  chunk_length_o;
  logic        address_valid_o;
  logic [6:0]  new_address_o;

  usb_control_endpoint_handler_top #(
    .MAX_OUT_DATA(MAX_OUT),
    .NUM_STRINGS (STRINGS)
  ) DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .configuration_value_i(configuration_value_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .func_i               (func_i),
    .request_type_i       (request_type_i),
    .request_code_i       (request_code_i),
    .setup_value_i        (setup_value_i),
    .setup_index_i        (setup_index_i),
    .setup_length_i       (setup_length_i),
    .out_received_i       (out_received_i),
    .link_speed_i         (link_speed_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .action_o             (action_o),
    .data_source_o        (data_source_o),
    .chunk_offset_o       (chunk_offset_o),
    .chunk_length_o       (chunk_length_o),
    .address_valid_o      (address_valid_o),
    .new_address_o        (new_address_o)
  );

  // 100 MHz clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Endpoint state as the handler should hold it.
  int unsigned bytes_left = 0;
  logic [6:0]  max_packet = PKT_FULL;
  logic [5:0]  chunk_pos = 6'd0;
  logic [2:0]  chunk_src = SRC_STATUS;
  logic [7:0]  cfg_value = CFG_RESET;

  // Actions still to come from the handler, oldest first.
  result_t     pending_actions[$];

  // Directed table: event, whether the action is typed in, and that action.
  item_t       table_events[$];
  bit          table_typed[$];
  result_t     table_actions[$];

  int unsigned events_sent = 0;
  int unsigned actions_checked = 0;
  int unsigned configs_written = 0;
  int unsigned error_count = 0;
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;

  function automatic item_t mk_event(input logic [2:0] func, input logic [7:0] rtype,
                                     input logic [7:0] rcode, input logic [15:0] wvalue,
                                     input logic [15:0] windex, input logic [15:0] wlength,
                                     input logic [6:0] received, input logic [1:0] speed);
    item_t ev;
    ev.func = func;
    ev.request_type = rtype;
    ev.request_code = rcode;
    ev.setup_value = wvalue;
    ev.setup_index = windex;
    ev.setup_length = wlength;
    ev.out_received = received;
    ev.link_speed = speed;
    return ev;
  endfunction

  function automatic result_t mk_result(input action_e act, input logic [2:0] src,
                                        input logic [5:0] offset, input logic [6:0] len,
                                        input logic addr_ok, input logic [6:0] addr);
    result_t r;
    r.action = act;
    r.data_source = src;
    r.chunk_offset = offset;
    r.chunk_length = len;
    r.address_valid = addr_ok;
    r.new_address = addr;
    return r;
  endfunction

  // Table row whose action is typed in.
  function automatic void row(input item_t ev, input result_t want);
    table_events.push_back(ev);
    table_typed.push_back(1'b1);
    table_actions.push_back(want);
  endfunction

  // Table row whose action comes from the predictor.
  function automatic void row_pred(input item_t ev);
    table_events.push_back(ev);
    table_typed.push_back(1'b0);
    table_actions.push_back(mk_result(ACT_NONE, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
  endfunction

  // Computes the action for one event and advances the endpoint state.
  function automatic result_t endpoint_action(input item_t ev);
    result_t     r;
    logic [15:0] req;
    logic [7:0]  dtype;
    logic [7:0]  didx;
    int unsigned len;
    logic [2:0]  src;
    bit          found;
    r = mk_result(ACT_NONE, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0);
    req = {ev.request_code, ev.request_type};
    dtype = ev.setup_value[15:8];
    didx = ev.setup_value[7:0];
    len = 0;
    src = SRC_STATUS;
    found = 1'b0;
    case (ev.func)
      FUNC_SETUP: begin
        bytes_left = 0;
        chunk_pos = 6'd0;
        if (ev.request_type[7]) begin
          // Device-to-host: look up the reply and its length.
          if (req == REQ_GET_STATUS) begin
            found = 1'b1;
            len = 32'(LEN_STATUS);
            src = SRC_STATUS;
          end else if (req == REQ_GET_DESCRIPTOR) begin
            if (dtype == DESC_DEVICE && didx == 8'd0) begin
              found = 1'b1;
              len = 32'(LEN_DEVICE);
              src = SRC_DEVICE;
            end else if (dtype == DESC_CONFIG && didx == 8'd0) begin
              found = 1'b1;
              len = 32'(LEN_CONFIG);
              src = SRC_CONFIG;
            end else if (dtype == DESC_STRING && 32'(didx) < STRINGS) begin
              found = 1'b1;
              src = SRC_STRING0 + didx[2:0];
              case (didx[1:0])
                2'd0: len = 4;
                2'd1: len = 16;
                2'd2: len = 22;
                default: len = 26;
              endcase
            end
          end else if (req == REQ_GET_CONFIG) begin
            found = 1'b1;
            len = 32'(LEN_CFG_VAL);
            src = SRC_CFG_VAL;
          end
          if (found) begin
            if (32'(ev.setup_length) < len) len = 32'(ev.setup_length);
            bytes_left = len;
            chunk_src = src;
            r.action = ACT_IN_FIRST;
            r.data_source = src;
            r.chunk_length = (len < 32'(max_packet)) ? 7'(len) : max_packet;
          end else begin
            r.action = ACT_STALL;
          end
        end else if (ev.setup_length == 16'd0) begin
          // Host-to-device without a data stage.
          if (req == REQ_SET_ADDRESS) begin
            r.action = ACT_ACK;
            r.address_valid = 1'b1;
            r.new_address = ev.setup_value[6:0];
          end else if (req == REQ_SET_CONFIG && ev.setup_index == 16'd0 &&
                       ev.setup_value == {8'd0, cfg_value}) begin
            r.action = ACT_ACK;
          end else begin
            r.action = ACT_STALL;
          end
        end else if (32'(ev.setup_length) <= MAX_OUT) begin
          bytes_left = 32'(ev.setup_length[6:0]);
          r.action = ACT_OUT_ARM;
          r.chunk_length = max_packet;
        end else begin
          r.action = ACT_STALL;
        end
      end
      FUNC_IN_DONE: begin
        if (bytes_left != 0) begin
          if (bytes_left > 32'(max_packet)) begin
            bytes_left = bytes_left - 32'(max_packet);
            chunk_pos = chunk_pos + max_packet[5:0];
            r.action = ACT_IN_NEXT;
            r.data_source = chunk_src;
            r.chunk_offset = chunk_pos;
            r.chunk_length = (bytes_left < 32'(max_packet)) ? 7'(bytes_left) : max_packet;
          end else begin
            bytes_left = 0;
          end
        end
      end
      FUNC_OUT_DONE: begin
        // The OUT data stage always ends in a stall; underflow saturates.
        if (bytes_left != 0) begin
          bytes_left = (32'(ev.out_received) >= bytes_left) ? 0 :
                       bytes_left - 32'(ev.out_received);
          if (bytes_left != 0) begin
            r.action = ACT_OUT_ARM;
            r.chunk_length = max_packet;
          end else begin
            r.action = ACT_STALL;
          end
        end
      end
      FUNC_BUS_RESET: bytes_left = 0;
      FUNC_ENUM_DONE: begin
        if (ev.link_speed == SPEED_LOW) max_packet = PKT_LOW;
        else if (ev.link_speed == SPEED_FULL) max_packet = PKT_FULL;
        else r.action = ACT_SPEED_ERR;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Offers one event after a random gap and records its action on transfer.
  task automatic send_event(input item_t ev, input bit typed, input result_t want);
    int unsigned gap;
    result_t     pred;
    gap = sender_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= ev.func;
    request_type_i <= ev.request_type;
    request_code_i <= ev.request_code;
    setup_value_i <= ev.setup_value;
    setup_index_i <= ev.setup_index;
    setup_length_i <= ev.setup_length;
    out_received_i <= ev.out_received;
    link_speed_i <= ev.link_speed;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = endpoint_action(ev);
    pending_actions.push_back(typed ? want : pred);
    if (ev.func <= FUNC_ENUM_DONE) events_sent++;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
  endtask

  task automatic post_event(input item_t ev);
    send_event(ev, 1'b0, mk_result(ACT_NONE, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
  endtask

  // Writes the configuration value once the handler has drained.
  task automatic write_config(input logic [7:0] value);
    in_valid_i <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    configuration_value_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    cfg_value = value;
    configs_written++;
  endtask

  function automatic item_t random_event();
    item_t ev;
    ev.func = 3'($urandom_range(0, 7));
    ev.request_type = 8'($urandom);
    ev.request_code = 8'($urandom);
    ev.setup_value = 16'($urandom);
    ev.setup_index = 16'($urandom);
    ev.setup_length = 16'($urandom);
    ev.out_received = 7'($urandom_range(0, 64));
    ev.link_speed = 2'($urandom);
    return ev;
  endfunction

  // Random traffic: mostly complete control transfers, some noise.
  task automatic run_phase(input int unsigned quota);
    int unsigned start;
    int unsigned pick;
    item_t       ev;
    start = events_sent;
    while (events_sent - start < quota) begin
      pick = $urandom_range(0, 99);
      ev = random_event();
      ev.func = FUNC_SETUP;
      if (pick < 35) begin
        // Read request followed by IN completions.
        case ($urandom_range(0, 5))
          0: {ev.request_code, ev.request_type} = REQ_GET_STATUS;
          1, 2, 3: begin
            {ev.request_code, ev.request_type} = REQ_GET_DESCRIPTOR;
            ev.setup_value[15:8] = ($urandom_range(0, 9) == 0) ?
                                   8'($urandom) : 8'($urandom_range(DESC_DEVICE, DESC_STRING));
            ev.setup_value[7:0] = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                                  8'($urandom_range(0, (ev.setup_value[15:8] == DESC_STRING) ?
                                                     STRINGS : 0));
          end
          4: {ev.request_code, ev.request_type} = REQ_GET_CONFIG;
          default: ev.request_type[7] = 1'b1;
        endcase
        case ($urandom_range(0, 3))
          0: ev.setup_length = 16'hFFFF;
          1: ev.setup_length = 16'($urandom_range(0, 30));
          2: ev.setup_length = 16'($urandom_range(0, 3));
          default: ;
        endcase
        post_event(ev);
        repeat ($urandom_range(1, 5)) begin
          ev = random_event();
          ev.func = FUNC_IN_DONE;
          post_event(ev);
        end
      end else if (pick < 55) begin
        // Write request followed by OUT completions.
        ev.request_type[7] = 1'b0;
        ev.setup_length = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(65, 65535)) :
                          16'($urandom_range(1, MAX_OUT));
        post_event(ev);
        repeat ($urandom_range(1, 6)) begin
          ev = random_event();
          ev.func = FUNC_OUT_DONE;
          if ($urandom_range(0, 3) != 0) ev.out_received = 7'($urandom_range(0, 16));
          post_event(ev);
        end
      end else if (pick < 70) begin
        // Requests without a data stage.
        ev.setup_length = 16'd0;
        if ($urandom_range(0, 1) == 0) begin
          {ev.request_code, ev.request_type} = REQ_SET_ADDRESS;
        end else begin
          {ev.request_code, ev.request_type} = REQ_SET_CONFIG;
          if ($urandom_range(0, 2) != 0) ev.setup_value = {8'd0, cfg_value};
          if ($urandom_range(0, 3) != 0) ev.setup_index = 16'd0;
        end
        if ($urandom_range(0, 7) == 0) ev.request_type[6:0] = 7'($urandom);
        post_event(ev);
      end else if (pick < 80) begin
        ev.func = FUNC_ENUM_DONE;
        post_event(ev);
      end else if (pick < 85) begin
        ev.func = FUNC_BUS_RESET;
        post_event(ev);
      end else begin
        post_event(random_event());
      end
    end
  endtask

  // Result side: random stalls, then compare each transfer with the oldest action.
  initial begin
    int unsigned hold;
    result_t     got;
    result_t     want;
    wait (rst_ni === 1'b1);
    forever begin
      hold = receiver_calm ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.action = action_e'(action_o);
      got.data_source = data_source_o;
      got.chunk_offset = chunk_offset_o;
      got.chunk_length = chunk_length_o;
      got.address_valid = address_valid_o;
      got.new_address = new_address_o;
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("action %0d arrived with nothing expected", action_o));
      end else begin
        want = pending_actions.pop_front();
        if (got.action !== want.action)
          report_mismatch($sformatf("result %0d action %0d, expected %0d",
                                    actions_checked, action_o, want.action));
        if (got.data_source !== want.data_source)
          report_mismatch($sformatf("result %0d data_source %0d, expected %0d",
                                    actions_checked, got.data_source, want.data_source));
        if (got.chunk_offset !== want.chunk_offset)
          report_mismatch($sformatf("result %0d chunk_offset %0d, expected %0d",
                                    actions_checked, got.chunk_offset, want.chunk_offset));
        if (got.chunk_length !== want.chunk_length)
          report_mismatch($sformatf("result %0d chunk_length %0d, expected %0d",
                                    actions_checked, got.chunk_length, want.chunk_length));
        if (got.address_valid !== want.address_valid)
          report_mismatch($sformatf("result %0d address_valid %0d, expected %0d",
                                    actions_checked, got.address_valid, want.address_valid));
        if (got.new_address !== want.new_address)
          report_mismatch($sformatf("result %0d new_address %0h, expected %0h",
                                    actions_checked, got.new_address, want.new_address));
        actions_checked++;
      end
      if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
    end
  end

  // Stimulus: directed table, then random phases under several configuration values.
  initial begin
    int idx;
    // Apply reset before the first clock edge.
    rst_ni <= 1'b0;
    // Replies and their truncation, with the reset packet size of 64.
    row(mk_event(FUNC_SETUP, 8'h80, 8'h00, 16'h0000, 16'h0000, 16'h0002, 7'd0, 2'd0),
        mk_result(ACT_IN_FIRST, SRC_STATUS, 6'd0, 7'd2, 1'b0, 7'd0));
    row(mk_event(FUNC_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 7'd0, 2'd0),
        mk_result(ACT_NONE, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    row(mk_event(FUNC_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 7'd5, 2'd0),
        mk_result(ACT_NONE, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    row(mk_event(FUNC_SETUP, 8'h80, 8'h06, 16'h0100, 16'h0000, 16'hFFFF, 7'd0, 2'd0),
        mk_result(ACT_IN_FIRST, SRC_DEVICE, 6'd0, 7'd18, 1'b0, 7'd0));
    row(mk_event(FUNC_SETUP, 8'h80, 8'h06, 16'h0200, 16'h0000, 16'h0005, 7'd0, 2'd0),
        mk_result(ACT_IN_FIRST, SRC_CONFIG, 6'd0, 7'd5, 1'b0, 7'd0));
    row(mk_event(FUNC_SETUP, 8'h80, 8'h06, 16'h0303, 16'h0409, 16'hFFFF, 7'd0, 2'd0),
        mk_result(ACT_IN_FIRST, SRC_STRING0 + 3'd3, 6'd0, 7'd26, 1'b0, 7'd0));
    // Descriptor index out of range and unknown descriptor type.
    row(mk_event(FUNC_SETUP, 8'h80, 8'h06, 16'h0304, 16'h0000, 16'hFFFF, 7'd0, 2'd0),
        mk_result(ACT_STALL, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    row(mk_event(FUNC_SETUP, 8'h80, 8'h06, 16'hFF00, 16'hFFFF, 16'hFFFF, 7'd0, 2'd0),
        mk_result(ACT_STALL, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    // A zero-length reply still gives a first chunk.
    row(mk_event(FUNC_SETUP, 8'h80, 8'h06, 16'h0100, 16'h0000, 16'h0000, 7'd0, 2'd0),
        mk_result(ACT_IN_FIRST, SRC_DEVICE, 6'd0, 7'd0, 1'b0, 7'd0));
    row(mk_event(FUNC_SETUP, 8'h80, 8'h08, 16'h0000, 16'h0000, 16'h0001, 7'd0, 2'd0),
        mk_result(ACT_IN_FIRST, SRC_CFG_VAL, 6'd0, 7'd1, 1'b0, 7'd0));
    // Requests without a data stage.
    row(mk_event(FUNC_SETUP, 8'h00, 8'h05, 16'hFFFF, 16'h0000, 16'h0000, 7'd0, 2'd0),
        mk_result(ACT_ACK, SRC_STATUS, 6'd0, 7'd0, 1'b1, 7'h7F));
    row(mk_event(FUNC_SETUP, 8'h00, 8'h09, 16'h0001, 16'h0000, 16'h0000, 7'd0, 2'd0),
        mk_result(ACT_ACK, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    row(mk_event(FUNC_SETUP, 8'h00, 8'h09, 16'h0001, 16'h0001, 16'h0000, 7'd0, 2'd0),
        mk_result(ACT_STALL, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    row(mk_event(FUNC_SETUP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd0, 2'd0),
        mk_result(ACT_STALL, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    row(mk_event(FUNC_SETUP, 8'h00, 8'h03, 16'h0001, 16'h0000, 16'h0000, 7'd0, 2'd0),
        mk_result(ACT_STALL, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    // OUT data stage at its largest, then underflow ends it in a stall.
    row(mk_event(FUNC_SETUP, 8'h40, 8'h01, 16'h0000, 16'h0000, 16'h0040, 7'd0, 2'd0),
        mk_result(ACT_OUT_ARM, SRC_STATUS, 6'd0, 7'd64, 1'b0, 7'd0));
    row_pred(mk_event(FUNC_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 7'd10, 2'd0));
    row(mk_event(FUNC_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 7'd64, 2'd0),
        mk_result(ACT_STALL, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    row(mk_event(FUNC_SETUP, 8'h40, 8'h01, 16'h0000, 16'h0000, 16'h0041, 7'd0, 2'd0),
        mk_result(ACT_STALL, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    // Low speed: 8-byte chunks, a reset mid-reply, then the error speed.
    row(mk_event(FUNC_ENUM_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 7'd0, SPEED_LOW),
        mk_result(ACT_NONE, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    row_pred(mk_event(FUNC_SETUP, 8'h80, 8'h06, 16'h0302, 16'h0000, 16'hFFFF, 7'd0, 2'd0));
    row_pred(mk_event(FUNC_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 7'd0, 2'd0));
    row(mk_event(FUNC_BUS_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 7'd0, 2'd0),
        mk_result(ACT_NONE, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    row(mk_event(FUNC_ENUM_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 7'd0, 2'd0),
        mk_result(ACT_SPEED_ERR, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    row(mk_event(FUNC_ENUM_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 7'd0, SPEED_FULL),
        mk_result(ACT_NONE, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));
    // An unused event code is ignored.
    row(mk_event(3'd7, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd64, 2'd3),
        mk_result(ACT_NONE, SRC_STATUS, 6'd0, 7'd0, 1'b0, 7'd0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (idx = 0; idx < table_events.size(); idx++)
      send_event(table_events[idx], table_typed[idx], table_actions[idx]);

    write_config(8'hFF);
    run_phase(250);
    write_config(8'h00);
    run_phase(250);
    write_config(8'($urandom_range(2, 254)));
    run_phase(250);
    write_config(8'($urandom));
    run_phase(250);
    write_config(CFG_RESET);
    run_phase(250);

    // Drain the pipeline and let it settle.
    in_valid_i <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d endpoint events, %0d actions compared, %0d configuration values.",
             events_sent, actions_checked, configs_written);
    if (error_count == 0) begin
      $display("usb_control_endpoint_handler_top_tb OK");
    end else begin
      $display("usb_control_endpoint_handler_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("usb_control_endpoint_handler_top_tb NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ucep_pkg.sv
hdl/ucep_in_stage.sv
hdl/ucep_core.sv
hdl/ucep_out_stage.sv
hdl/usb_control_endpoint_handler_top.sv
hdl/ucep_checker.sv
bench/usb_control_endpoint_handler_top_tb.sv
